### sv/rabs_pkg.sv
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared constants, register codes and the gray conversion for the running
// average background subtractor.
// ----------------------------------------------------------------------------
package rabs_pkg;

	localparam int DEF_MAX_PIXELS = 524288;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_RATE     = 1'd1;

	localparam logic [7:0]  DIFF_THRESHOLD_RESET = 8'd60;
	localparam logic [15:0] BLEND_RATE_RESET     = 16'd197;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] FG_ON  = 8'd255;
	localparam logic [7:0] FG_OFF = 8'd0;

	localparam logic [21:0] GRAY_R    = 22'd4899;
	localparam logic [21:0] GRAY_G    = 22'd9617;
	localparam logic [21:0] GRAY_B    = 22'd1868;
	localparam logic [21:0] GRAY_HALF = 22'd8192;

	// weights sum to 2^14, so the sum stays below 2^22
	function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [21:0] sum;
		sum = {14'b0, r} * GRAY_R + {14'b0, g} * GRAY_G + {14'b0, b} * GRAY_B + GRAY_HALF;
		return sum[21:14];
	endfunction

endpackage

### sv/rabs_if.sv
// ----------------------------------------------------------------------------
// rabs_if
// Stream interfaces for pixel beats in and result beats out.
// ----------------------------------------------------------------------------
interface rabs_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;
	logic       frame_end;

	modport source (output valid, blue, green, red, frame_end, input ready);
	modport sink (input valid, blue, green, red, frame_end, output ready);
endinterface

interface rabs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] foreground;
	logic [7:0] background_level;
	logic       frame_done;

	modport source (output valid, foreground, background_level, frame_done, input ready);
	modport sink (input valid, foreground, background_level, frame_done, output ready);
endinterface

### sv/running_average_background_subtract.sv
// ----------------------------------------------------------------------------
// running_average_background_subtract
// Running average background subtraction on a raster stream of colour pixels.
// ----------------------------------------------------------------------------
// pixel: valid/ready beats of blue, green, red and frame_end in raster order.
// result: one beat per pixel with foreground (0 or 255), the rounded updated
//   background level and frame_done, in pixel order.
// cfg: cfg_we writes diff_threshold (index 0) or blend_rate (index 1); write
//   only while no pixel is in flight.
// Path: an accepted pixel beat goes through the queue, stage 1, stage 2 and the output register.
// Throughput: one pixel per cycle while the result is not stalled, with one read and
//   one write of the frame store each; a pixel outside the learning frame that hits
//   the same store entry as one of the two before it (frames shorter than 3 pixels, or
//   pixels past the store size that share the last entry) waits for that write.
// Reset: address returns to 0 and the next frame is a learning frame that
//   loads the store with gray values; the store itself is not cleared.
// A stalled result holds the back pipeline; the front keeps accepting until
//   its 4-entry queue is full, then drops pixel.ready.
// ----------------------------------------------------------------------------
module running_average_background_subtract
	import rabs_pkg::*;
#(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rabs_pixel_if.sink            pixel,
	rabs_result_if.source         result
);

	localparam int EW = 8 + $clog2(MAX_PIXELS) + 2;

	logic          push_valid;
	logic          push_ready;
	logic [EW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [EW-1:0] pop_data;

	rabs_front #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rabs_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rabs_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

### sv/rabs_queue.sv
// ----------------------------------------------------------------------------
// rabs_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rabs_queue
	import rabs_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/rabs_front.sv
// ----------------------------------------------------------------------------
// rabs_front
// Accepts pixel beats, converts to gray, tracks the pixel address and the
// learning frame, and pushes one work entry per pixel.
// ----------------------------------------------------------------------------
module rabs_front
	import rabs_pkg::*;
#(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rabs_pixel_if.sink                          pixel,
	output logic                                push_valid,
	input  logic                                push_ready,
	output logic [8+$clog2(MAX_PIXELS)+2-1:0]   push_data
);

	localparam int AW = $clog2(MAX_PIXELS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

	logic [AW-1:0] addr_q;
	logic          learn_q;
	logic          take;

	assign pixel.ready = push_ready;
	assign push_valid  = pixel.valid;
	assign take        = pixel.valid && push_ready;
	assign push_data   = {gray_of(pixel.red, pixel.green, pixel.blue), addr_q, learn_q,
		pixel.frame_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			learn_q <= 1'b1;
		end else if (take) begin
			if (pixel.frame_end) begin
				addr_q  <= '0;
				learn_q <= 1'b0;
			end else if (addr_q != LAST_ADDR) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

endmodule

### sv/rabs_back.sv
// ----------------------------------------------------------------------------
// rabs_back
// Frame store pipeline: read the old background, compare and multiply,
// then blend, write back and present the result beat.
// ----------------------------------------------------------------------------
module rabs_back
	import rabs_pkg::*;
#(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_wdata,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  logic [8+$clog2(MAX_PIXELS)+2-1:0]   pop_data,
	rabs_result_if.source                       result
);

	localparam int AW = $clog2(MAX_PIXELS);

	logic [7:0]  thr_q;
	logic [15:0] blend_q;

	logic [23:0] bg_mem [MAX_PIXELS];

	// head of queue
	logic [7:0]    h_gray;
	logic [AW-1:0] h_addr;
	logic          h_learn;
	logic          h_end;
	logic          hazard;
	logic          advance;

	// stage 1: read issued
	logic          v_s1;
	logic [7:0]    gray_s1;
	logic [AW-1:0] addr_s1;
	logic          learn_s1;
	logic          end_s1;
	logic [23:0]   rdata_q;

	// stage 2: product ready
	logic          v_s2;
	logic [7:0]    gray_s2;
	logic [AW-1:0] addr_s2;
	logic          learn_s2;
	logic          end_s2;
	logic [23:0]   old_s2;
	logic          up_s2;
	logic          fg_s2;
	logic [39:0]   prod_s2;

	// output register
	logic          out_valid_q;
	logic [7:0]    fg_q;
	logic [7:0]    level_q;
	logic          done_q;

	logic [23:0] target_c;
	logic        up_c;
	logic [23:0] mag_c;
	logic [39:0] round_c;
	logic [23:0] delta_c;
	logic [24:0] sum_c;
	logic [23:0] bg_c;
	logic [24:0] lvl_c;
	logic [7:0]  level_c;

	assign {h_gray, h_addr, h_learn, h_end} = pop_data;

	assign advance = !out_valid_q || result.ready;
	// an older pixel at the same address is still in flight and not yet written
	assign hazard  = !h_learn && ((v_s1 && addr_s1 == h_addr) || (v_s2 && addr_s2 == h_addr));
	assign pop_ready = advance && !hazard;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= DIFF_THRESHOLD_RESET;
			blend_q <= BLEND_RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIFF_THRESHOLD: thr_q   <= cfg_wdata[7:0];
				REG_BLEND_RATE:     blend_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// compare and multiply on the read data
	always_comb begin
		target_c = {gray_s1, 16'b0};
		up_c     = target_c >= rdata_q;
		mag_c    = up_c ? target_c - rdata_q : rdata_q - target_c;
	end

	// blend, clamp and round to the output level
	always_comb begin
		round_c = prod_s2 + 40'd32768;
		delta_c = round_c[39:16];
		sum_c   = {1'b0, old_s2} + {1'b0, delta_c};
		if (learn_s2) begin
			bg_c = {gray_s2, 16'b0};
		end else if (up_s2) begin
			bg_c = sum_c[24] ? 24'hFFFFFF : sum_c[23:0];
		end else begin
			bg_c = (delta_c > old_s2) ? 24'd0 : old_s2 - delta_c;
		end
		lvl_c   = {1'b0, bg_c} + 25'd32768;
		level_c = lvl_c[24] ? 8'd255 : lvl_c[23:16];
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2) begin
			bg_mem[addr_s2] <= bg_c;
		end
		if (pop_valid && pop_ready) begin
			rdata_q <= bg_mem[h_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= pop_valid && !hazard;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gray_s1  <= h_gray;
			addr_s1  <= h_addr;
			learn_s1 <= h_learn;
			end_s1   <= h_end;

			gray_s2  <= gray_s1;
			addr_s2  <= addr_s1;
			learn_s2 <= learn_s1;
			end_s2   <= end_s1;
			old_s2   <= rdata_q;
			up_s2    <= up_c;
			fg_s2    <= mag_c > {thr_q, 16'b0};
			prod_s2  <= {24'b0, blend_q} * {16'b0, mag_c};

			fg_q    <= (!learn_s2 && fg_s2) ? FG_ON : FG_OFF;
			level_q <= level_c;
			done_q  <= end_s2;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.foreground       = fg_q;
	assign result.background_level = level_q;
	assign result.frame_done       = done_q;

endmodule
